@@ hdl/heq_pkg.sv @@
// ----------------------------------------------------------------------------
// heq_pkg
// Shared types and codes for the haptic event qualifier.
// ----------------------------------------------------------------------------
package heq_pkg;

  // request action codes
  localparam logic [3:0] ACT_SELECT      = 4'd0;
  localparam logic [3:0] ACT_PICKUP      = 4'd1;
  localparam logic [3:0] ACT_DROP        = 4'd2;
  localparam logic [3:0] ACT_BOUNDARY    = 4'd3;
  localparam logic [3:0] ACT_DETENT      = 4'd4;
  localparam logic [3:0] ACT_CONFIRM     = 4'd5;
  localparam logic [3:0] ACT_PRESS       = 4'd6;
  localparam logic [3:0] ACT_TOGGLE      = 4'd7;
  localparam logic [3:0] ACT_SUCCESS     = 4'd8;
  localparam logic [3:0] ACT_ERROR       = 4'd9;
  localparam logic [3:0] ACT_SNAP        = 4'd10;
  localparam logic [3:0] ACT_LANE        = 4'd11;
  localparam logic [3:0] ACT_TRIM        = 4'd12;
  localparam logic [3:0] ACT_SET_ENABLED = 4'd13;
  localparam logic [3:0] ACT_RESET       = 4'd14;
  // spare code, ignored by the block
  localparam logic [3:0] ACT_UNUSED      = 4'd15;

  // actuator effect codes
  localparam logic [3:0] FX_SELECT   = 4'd0;
  localparam logic [3:0] FX_PICKUP   = 4'd1;
  localparam logic [3:0] FX_DROP     = 4'd2;
  localparam logic [3:0] FX_BOUNDARY = 4'd3;
  localparam logic [3:0] FX_DETENT   = 4'd4;
  localparam logic [3:0] FX_CONFIRM  = 4'd5;
  localparam logic [3:0] FX_PRESS    = 4'd6;
  localparam logic [3:0] FX_ON       = 4'd7;
  localparam logic [3:0] FX_OFF      = 4'd8;
  localparam logic [3:0] FX_SUCCESS  = 4'd9;
  localparam logic [3:0] FX_ERROR    = 4'd10;
  localparam logic [3:0] FX_SNAP     = 4'd11;

  // trim outcome codes
  localparam logic [1:0] TRIM_NONE    = 2'd0;
  localparam logic [1:0] TRIM_MOVED   = 2'd1;
  localparam logic [1:0] TRIM_SNAPPED = 2'd2;
  localparam logic [1:0] TRIM_BLOCKED = 2'd3;

  // configuration register indexes
  localparam logic REG_MIN_INTERVAL = 1'b0;
  localparam logic REG_SNAP_EPSILON = 1'b1;

  localparam logic [15:0] MIN_INTERVAL_RESET = 16'd40;
  localparam logic [15:0] SNAP_EPSILON_RESET = 16'd500;

  localparam logic signed [32:0] SNAP_NONE = -33'sd1;
  localparam logic signed [8:0]  LANE_NONE = -9'sd1;

  typedef struct packed {
    logic [15:0] min_interval_ms;
    logic [15:0] snap_epsilon_us;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         action;
    logic [31:0]        now_ms;
    logic signed [32:0] target_us;
    logic signed [8:0]  lane_index;
    logic [1:0]         trim_outcome;
    logic               flag_on;
  } item_t;

  typedef struct packed {
    logic               enabled;
    logic [31:0]        last_fire_ms;
    logic signed [32:0] snap_latch;
    logic signed [8:0]  lane_latch;
    logic [1:0]         trim_latch;
  } state_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] effect_code;
    logic       enabled_now;
  } result_t;

endpackage

@@ hdl/heq_if.sv @@
// ----------------------------------------------------------------------------
// heq_if
// Valid/ready channels for haptic requests and qualifier results.
// ----------------------------------------------------------------------------
interface heq_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic [31:0]        now_ms;
  logic signed [32:0] target_us;
  logic signed [8:0]  lane_index;
  logic [1:0]         trim_outcome;
  logic               flag_on;

  modport source (
    output valid, action, now_ms, target_us, lane_index, trim_outcome, flag_on,
    input  ready
  );
  modport sink (
    input  valid, action, now_ms, target_us, lane_index, trim_outcome, flag_on,
    output ready
  );
endinterface

interface heq_res_if;
  logic       valid;
  logic       ready;
  logic       fired;
  logic [3:0] effect_code;
  logic       enabled_now;

  modport source (
    output valid, fired, effect_code, enabled_now,
    input  ready
  );
  modport sink (
    input  valid, fired, effect_code, enabled_now,
    output ready
  );
endinterface

@@ hdl/heq_regs.sv @@
// ----------------------------------------------------------------------------
// heq_regs
// Configuration registers: minimum tick interval and snap epsilon.
// ----------------------------------------------------------------------------
module heq_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  output heq_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ms <= heq_pkg::MIN_INTERVAL_RESET;
      cfg.snap_epsilon_us <= heq_pkg::SNAP_EPSILON_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        heq_pkg::REG_MIN_INTERVAL: cfg.min_interval_ms <= cfg_data;
        heq_pkg::REG_SNAP_EPSILON: cfg.snap_epsilon_us <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/heq_decide.sv @@
// ----------------------------------------------------------------------------
// heq_decide
// Per-word decision: next latch state and the effect to issue, if any.
// ----------------------------------------------------------------------------
module heq_decide (
  input  heq_pkg::cfg_t    cfg,
  input  heq_pkg::state_t  st,
  input  heq_pkg::item_t   item,
  output heq_pkg::state_t  st_next,
  output heq_pkg::result_t res
);

  logic [31:0]        elapsed;
  logic               too_soon;
  logic signed [33:0] snap_diff;
  logic [33:0]        snap_abs;
  logic               snap_near;
  logic               want;
  logic               en_fire;
  logic [3:0]         code;
  logic               stackable;
  logic               fire;

  assign elapsed  = item.now_ms - st.last_fire_ms;
  assign too_soon = (st.last_fire_ms != 32'd0) && (elapsed < {16'd0, cfg.min_interval_ms});

  assign snap_diff = {item.target_us[32], item.target_us} - {st.snap_latch[32], st.snap_latch};
  assign snap_abs  = snap_diff[33] ? 34'(-snap_diff) : 34'(snap_diff);
  // only meaningful while a target is latched
  assign snap_near = !st.snap_latch[32] && (snap_abs < {18'd0, cfg.snap_epsilon_us});

  always_comb begin
    st_next = st;
    want    = 1'b0;
    code    = heq_pkg::FX_SELECT;
    en_fire = st.enabled;

    case (item.action)
      heq_pkg::ACT_SELECT: begin
        want = 1'b1;
        code = heq_pkg::FX_SELECT;
      end
      heq_pkg::ACT_PICKUP: begin
        want = 1'b1;
        code = heq_pkg::FX_PICKUP;
      end
      heq_pkg::ACT_DROP: begin
        st_next.snap_latch = heq_pkg::SNAP_NONE;
        st_next.lane_latch = heq_pkg::LANE_NONE;
        st_next.trim_latch = heq_pkg::TRIM_NONE;
        want = 1'b1;
        code = heq_pkg::FX_DROP;
      end
      heq_pkg::ACT_BOUNDARY: begin
        want = 1'b1;
        code = heq_pkg::FX_BOUNDARY;
      end
      heq_pkg::ACT_DETENT: begin
        want = 1'b1;
        code = heq_pkg::FX_DETENT;
      end
      heq_pkg::ACT_CONFIRM: begin
        want = 1'b1;
        code = heq_pkg::FX_CONFIRM;
      end
      heq_pkg::ACT_PRESS: begin
        want = 1'b1;
        code = heq_pkg::FX_PRESS;
      end
      heq_pkg::ACT_TOGGLE: begin
        want = 1'b1;
        code = item.flag_on ? heq_pkg::FX_ON : heq_pkg::FX_OFF;
      end
      heq_pkg::ACT_SUCCESS: begin
        want = 1'b1;
        code = heq_pkg::FX_SUCCESS;
      end
      heq_pkg::ACT_ERROR: begin
        want = 1'b1;
        code = heq_pkg::FX_ERROR;
      end
      heq_pkg::ACT_SNAP: begin
        if (item.target_us[32]) begin
          st_next.snap_latch = heq_pkg::SNAP_NONE;
        end else if (!snap_near) begin
          // latch moves even when the tick gets rate limited
          st_next.snap_latch = item.target_us;
          want = 1'b1;
          code = heq_pkg::FX_SNAP;
        end
      end
      heq_pkg::ACT_LANE: begin
        if (item.lane_index[8]) begin
          st_next.lane_latch = heq_pkg::LANE_NONE;
        end else if (item.lane_index != st.lane_latch) begin
          st_next.lane_latch = item.lane_index;
          // first lane after none is silent
          want = !st.lane_latch[8];
          code = heq_pkg::FX_DETENT;
        end
      end
      heq_pkg::ACT_TRIM: begin
        if (item.trim_outcome != heq_pkg::TRIM_NONE) begin
          st_next.trim_latch = item.trim_outcome;
          if (item.trim_outcome != st.trim_latch) begin
            case (item.trim_outcome)
              heq_pkg::TRIM_SNAPPED: begin
                want = 1'b1;
                code = heq_pkg::FX_SNAP;
              end
              heq_pkg::TRIM_BLOCKED: begin
                want = 1'b1;
                code = heq_pkg::FX_BOUNDARY;
              end
              default: ;
            endcase
          end
        end
      end
      heq_pkg::ACT_SET_ENABLED: begin
        if (item.flag_on != st.enabled) begin
          st_next.enabled    = item.flag_on;
          st_next.snap_latch = heq_pkg::SNAP_NONE;
          st_next.lane_latch = heq_pkg::LANE_NONE;
          st_next.trim_latch = heq_pkg::TRIM_NONE;
          en_fire = item.flag_on;
          want    = item.flag_on;
          code    = heq_pkg::FX_ON;
        end
      end
      heq_pkg::ACT_RESET: begin
        st_next.snap_latch = heq_pkg::SNAP_NONE;
        st_next.lane_latch = heq_pkg::LANE_NONE;
        st_next.trim_latch = heq_pkg::TRIM_NONE;
      end
      default: ;
    endcase

    stackable = (code == heq_pkg::FX_SELECT) || (code == heq_pkg::FX_DETENT) ||
                (code == heq_pkg::FX_PRESS)  || (code == heq_pkg::FX_SNAP);
    fire = want && en_fire && !(stackable && too_soon);

    if (fire) begin
      st_next.last_fire_ms = item.now_ms;
    end

    res.fired       = fire;
    res.effect_code = fire ? code : heq_pkg::FX_SELECT;
    res.enabled_now = st_next.enabled;
  end

endmodule

@@ hdl/haptic_event_qualifier.sv @@
// ----------------------------------------------------------------------------
// haptic_event_qualifier
// Decides per haptic request whether an actuator effect fires.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word (action, time stamp, snap target, lane,
//   trim outcome, flag). res carries one result word per request: fired,
//   effect code and the enable flag after the request.
//   cfg_we/cfg_index/cfg_data write the minimum tick interval (index 0) and
//   the snap epsilon (index 1); write only while no request is in flight.
// Timing and throughput:
//   a request's result is registered and shows on res in the cycle after it
//   is accepted; one request per cycle is taken while res is not held, set
//   by the single state update loop (latches and last fire time).
// Reset:
//   rst empties the result stage, enables the block, clears all latches,
//   marks the last fire time as never and loads the register defaults
//   (40 ms, 500 us). req.ready is low during reset.
// Stall:
//   while res is held, req.ready stays high only if the result is taken in
//   the same cycle, so the pending word is never overwritten.
// ----------------------------------------------------------------------------
module haptic_event_qualifier (
  input  logic        clk,
  input  logic        rst,
  heq_req_if.sink     req,
  heq_res_if.source   res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  heq_pkg::cfg_t    cfg;
  heq_pkg::state_t  st;
  heq_pkg::state_t  st_next;
  heq_pkg::item_t   item;
  heq_pkg::result_t rslt_next;
  heq_pkg::result_t rslt;
  logic             out_valid;
  logic             accept;

  heq_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign item.action       = req.action;
  assign item.now_ms       = req.now_ms;
  assign item.target_us    = req.target_us;
  assign item.lane_index   = req.lane_index;
  assign item.trim_outcome = req.trim_outcome;
  assign item.flag_on      = req.flag_on;

  heq_decide u_decide (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (rslt_next)
  );

  assign req.ready = !rst && (!out_valid || res.ready);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.enabled      <= 1'b1;
      st.last_fire_ms <= 32'd0;
      st.snap_latch   <= heq_pkg::SNAP_NONE;
      st.lane_latch   <= heq_pkg::LANE_NONE;
      st.trim_latch   <= heq_pkg::TRIM_NONE;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      rslt <= rslt_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.fired       = rslt.fired;
  assign res.effect_code = rslt.effect_code;
  assign res.enabled_now = rslt.enabled_now;

endmodule

@@ hdl/heq_checker.sv @@
// ----------------------------------------------------------------------------
// heq_checker
// Port-level checks for the haptic event qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module heq_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [3:0] req_action,
  input logic       req_flag_on,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_fired,
  input logic [3:0] res_effect_code,
  input logic       res_enabled_now
);

  // every accepted word yields a result next cycle
  a_accept_gives_result: assert property (
    @(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> res_valid
  ) else $error("accepted request did not produce a result");

  a_silent_code_zero: assert property (
    @(posedge clk) disable iff (rst)
    (res_valid && !res_fired) |-> (res_effect_code == heq_pkg::FX_SELECT)
  ) else $error("effect code nonzero without a fire");

  a_code_range: assert property (
    @(posedge clk) disable iff (rst)
    (res_valid && res_fired) |-> (res_effect_code <= heq_pkg::FX_SNAP)
  ) else $error("effect code out of range");

  // set_enabled always leaves the flag equal to the requested value
  a_set_enabled: assert property (
    @(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_action == heq_pkg::ACT_SET_ENABLED))
      |=> (res_enabled_now == $past(req_flag_on))
  ) else $error("enable flag does not follow set_enabled");

  a_hold_on_stall: assert property (
    @(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid
  ) else $error("result dropped while stalled");

endmodule

bind haptic_event_qualifier heq_checker u_heq_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_action      (req.action),
  .req_flag_on     (req.flag_on),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_fired       (res.fired),
  .res_effect_code (res.effect_code),
  .res_enabled_now (res.enabled_now)
);
